// ----- rtl/gif_lzw_decoder_core_defines.svh -----
// Assertion macros used by the checker file.
`ifndef GIF_LZW_DECODER_CORE_DEFINES_SVH
`define GIF_LZW_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define GLZW_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gif lzw check failed");

// Next-cycle implication, checked at every clock edge outside reset.
`define GLZW_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gif lzw check failed");

`endif

// ----- rtl/glzw_pkg.sv -----
package glzw_pkg;

  // Actions of an input transaction.
  localparam logic [1:0] ACT_FEED    = 2'd0;
  localparam logic [1:0] ACT_PULL    = 2'd1;
  localparam logic [1:0] ACT_RESTART = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_BYTE      = 3'd0;
  localparam logic [2:0] ST_NEED      = 3'd1;
  localparam logic [2:0] ST_CLEAR     = 3'd2;
  localparam logic [2:0] ST_ENDED     = 3'd3;
  localparam logic [2:0] ST_ERROR     = 3'd4;
  localparam logic [2:0] ST_ACCEPTED  = 3'd5;
  localparam logic [2:0] ST_REFUSED   = 3'd6;
  localparam logic [2:0] ST_RESTARTED = 3'd7;

  // Bit buffer limits.
  localparam int unsigned BufBits  = 24;
  localparam int unsigned FeedMax  = 16;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [2:0] status;
    logic       string_end;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       capture;
    logic       feed;
    logic       restart;
    logic       take_code;
    logic       dict_init;
    logic       set_ended;
    logic       set_err;
    logic       walk_start;
    logic       walk_push;
    logic       walk_end;
    logic       pop;
    logic       load_out;
    logic [2:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic feed_ok;
    logic stack_nonempty;
    logic err;
    logic ended;
    logic bits_enough;
    logic code_clr;
    logic code_stop;
    logic code_bad;
    logic walk_root;
  } sts_t;

endpackage

// ----- rtl/glzw_ctrl.sv -----
module glzw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic [1:0]    in_action_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  glzw_pkg::sts_t sts_i,
  output glzw_pkg::cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_EXEC      = 3'd1;
  localparam logic [2:0] S_CLASS     = 3'd2;
  localparam logic [2:0] S_WALK_RD   = 3'd3;
  localparam logic [2:0] S_WALK_PUSH = 3'd4;
  localparam logic [2:0] S_POP       = 3'd5;
  localparam logic [2:0] S_OUT       = 3'd6;

  logic [2:0] state_q, state_d;
  logic [1:0] action_q, action_d;
  logic [2:0] res_q, res_d;
  logic       out_valid_q, out_valid_d;
  logic       accept;
  logic       out_free;

  assign accept      = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    action_d    = action_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_o.capture = 1'b1;
          action_d      = in_action_i;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_OUT;
        case (action_q)
          glzw_pkg::ACT_FEED: begin
            cmd_o.feed = sts_i.feed_ok;
            res_d = sts_i.feed_ok ? glzw_pkg::ST_ACCEPTED : glzw_pkg::ST_REFUSED;
          end
          glzw_pkg::ACT_RESTART: begin
            cmd_o.restart = 1'b1;
            res_d         = glzw_pkg::ST_RESTARTED;
          end
          glzw_pkg::ACT_PULL: begin
            if (sts_i.stack_nonempty) begin
              state_d = S_POP;
            end else if (sts_i.err) begin
              res_d = glzw_pkg::ST_ERROR;
            end else if (sts_i.ended) begin
              res_d = glzw_pkg::ST_ENDED;
            end else if (!sts_i.bits_enough) begin
              res_d = glzw_pkg::ST_NEED;
            end else begin
              cmd_o.take_code = 1'b1;
              state_d         = S_CLASS;
            end
          end
          default: begin
            res_d = glzw_pkg::ST_REFUSED;
          end
        endcase
      end
      S_CLASS: begin
        if (sts_i.code_clr) begin
          cmd_o.dict_init = 1'b1;
          res_d           = glzw_pkg::ST_CLEAR;
          state_d         = S_OUT;
        end else if (sts_i.code_stop) begin
          cmd_o.set_ended = 1'b1;
          res_d           = glzw_pkg::ST_ENDED;
          state_d         = S_OUT;
        end else if (sts_i.code_bad) begin
          cmd_o.set_err = 1'b1;
          res_d         = glzw_pkg::ST_ERROR;
          state_d       = S_OUT;
        end else begin
          cmd_o.walk_start = 1'b1;
          state_d          = S_WALK_RD;
        end
      end
      S_WALK_RD: begin
        if (sts_i.walk_root) begin
          cmd_o.walk_end = 1'b1;
          state_d        = S_POP;
        end else begin
          state_d = S_WALK_PUSH;
        end
      end
      S_WALK_PUSH: begin
        cmd_o.walk_push = 1'b1;
        state_d         = S_WALK_RD;
      end
      S_POP: begin
        cmd_o.pop = 1'b1;
        res_d     = glzw_pkg::ST_BYTE;
        state_d   = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    cmd_o.status = res_q;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      action_q    <= glzw_pkg::ACT_FEED;
      res_q       <= glzw_pkg::ST_BYTE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      action_q    <= action_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- rtl/glzw_dp.sv -----
module glzw_dp #(
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i,
  input  logic [7:0]     in_byte_i,
  input  glzw_pkg::cmd_t cmd_i,
  output glzw_pkg::sts_t sts_o,
  output glzw_pkg::out_t out_o
);

  localparam int unsigned P     = MAX_CODE_BITS;
  localparam int unsigned Depth = 1 << P;
  localparam int unsigned BW    = glzw_pkg::BufBits;

  logic [3:0]    mcs_q;
  logic [BW-1:0] buf_q;
  logic [4:0]    cnt_q;
  logic [P:0]    stk_cnt_q;
  logic [P:0]    next_free_q;
  logic [3:0]    cw_q;
  logic [P-1:0]  prev_code_q;
  logic          prev_valid_q;
  logic [7:0]    prev_first_q;
  logic          ended_q;
  logic          err_q;
  logic [P-1:0]  code_q;
  logic [P-1:0]  cur_q;
  logic [7:0]    byte_q;
  logic          kwk_q;
  glzw_pkg::out_t out_q;

  logic [P-1:0] prefix_mem [Depth];
  logic [7:0]   suffix_mem [Depth];
  logic [7:0]   stack_mem  [Depth];
  logic [P-1:0] pre_rd_q;
  logic [7:0]   suf_rd_q;
  logic [7:0]   stk_rd_q;

  logic [3:0]    eff;
  logic [P:0]    clr;
  logic [BW-1:0] mask;
  logic [P-1:0]  code_now;
  logic          push_en;
  logic [7:0]    push_byte;
  logic          dict_wr;
  logic [P:0]    nf_inc;
  logic [P:0]    stk_dec;

  // Effective minimum code size, saturated to two through eight.
  always_comb begin
    eff = mcs_q;
    if (mcs_q < 4'd2) begin
      eff = 4'd2;
    end else if (mcs_q > 4'd8) begin
      eff = 4'd8;
    end
  end

  assign clr      = (P+1)'(1) << eff;
  assign mask     = (BW'(1) << cw_q) - BW'(1);
  assign code_now = P'(buf_q & mask);
  assign nf_inc   = next_free_q + (P+1)'(1);
  assign stk_dec  = stk_cnt_q - (P+1)'(1);
  assign dict_wr  = cmd_i.walk_end && prev_valid_q && (next_free_q < (P+1)'(Depth));

  // Status toward the controller.
  always_comb begin
    sts_o.feed_ok        = (cnt_q <= 5'(glzw_pkg::FeedMax));
    sts_o.stack_nonempty = (stk_cnt_q != '0);
    sts_o.err            = err_q;
    sts_o.ended          = ended_q;
    sts_o.bits_enough    = (cnt_q >= 5'(cw_q));
    sts_o.code_clr       = ({1'b0, code_q} == clr);
    sts_o.code_stop      = ({1'b0, code_q} == clr + (P+1)'(1));
    sts_o.code_bad       = ({1'b0, code_q} > next_free_q) ||
                           (({1'b0, code_q} == next_free_q) && !prev_valid_q);
    sts_o.walk_root      = ({1'b0, cur_q} < clr);
  end

  // Byte pushed onto the string stack this cycle.
  always_comb begin
    push_en   = 1'b0;
    push_byte = 8'd0;
    if (cmd_i.walk_start && kwk_q) begin
      push_en   = 1'b1;
      push_byte = prev_first_q;
    end else if (cmd_i.walk_push) begin
      push_en   = 1'b1;
      push_byte = suf_rd_q;
    end else if (cmd_i.walk_end) begin
      push_en   = 1'b1;
      push_byte = cur_q[7:0];
    end
  end

  // Dictionary and stack memories with registered reads.
  always_ff @(posedge clk_i) begin
    pre_rd_q <= prefix_mem[cur_q];
    suf_rd_q <= suffix_mem[cur_q];
    if (dict_wr) begin
      prefix_mem[next_free_q[P-1:0]] <= prev_code_q;
      suffix_mem[next_free_q[P-1:0]] <= kwk_q ? prev_first_q : cur_q[7:0];
    end
    if (push_en && (stk_cnt_q < (P+1)'(Depth))) begin
      stack_mem[stk_cnt_q[P-1:0]] <= push_byte;
    end
    if (cmd_i.pop) begin
      stk_rd_q <= stack_mem[stk_dec[P-1:0]];
    end
  end

  // Payload registers without reset.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      byte_q <= in_byte_i;
    end
    if (cmd_i.take_code) begin
      code_q <= code_now;
    end
    if (cmd_i.walk_start) begin
      cur_q <= kwk_q ? prev_code_q : code_q;
    end else if (cmd_i.walk_push) begin
      cur_q <= pre_rd_q;
    end
    if (cmd_i.walk_end) begin
      prev_first_q <= cur_q[7:0];
    end
    if (cmd_i.load_out) begin
      out_q.status     <= cmd_i.status;
      out_q.pixel      <= (cmd_i.status == glzw_pkg::ST_BYTE) ? stk_rd_q : 8'd0;
      out_q.string_end <= (cmd_i.status == glzw_pkg::ST_BYTE) && (stk_cnt_q == '0);
    end
  end

  // Decoder state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mcs_q        <= 4'd8;
      buf_q        <= '0;
      cnt_q        <= '0;
      stk_cnt_q    <= '0;
      next_free_q  <= (P+1)'(258);
      cw_q         <= 4'd9;
      prev_code_q  <= '0;
      prev_valid_q <= 1'b0;
      ended_q      <= 1'b0;
      err_q        <= 1'b0;
      kwk_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        mcs_q <= cfg_wdata_i;
      end
      if (cmd_i.feed) begin
        buf_q <= buf_q | (BW'(byte_q) << cnt_q);
        cnt_q <= cnt_q + 5'd8;
      end
      if (cmd_i.take_code) begin
        buf_q <= buf_q >> cw_q;
        cnt_q <= cnt_q - 5'(cw_q);
      end
      if (cmd_i.restart || cmd_i.dict_init) begin
        next_free_q  <= clr + (P+1)'(2);
        cw_q         <= eff + 4'd1;
        prev_code_q  <= '0;
        prev_valid_q <= 1'b0;
      end
      if (cmd_i.restart) begin
        buf_q     <= '0;
        cnt_q     <= '0;
        stk_cnt_q <= '0;
        ended_q   <= 1'b0;
        err_q     <= 1'b0;
      end
      if (cmd_i.set_ended) begin
        ended_q <= 1'b1;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      // A code equal to the next free entry repeats the previous string.
      if (cmd_i.take_code) begin
        kwk_q <= ({1'b0, code_now} == next_free_q);
      end
      if (push_en && (stk_cnt_q < (P+1)'(Depth))) begin
        stk_cnt_q <= stk_cnt_q + (P+1)'(1);
      end
      if (cmd_i.pop) begin
        stk_cnt_q <= stk_dec;
      end
      if (dict_wr) begin
        next_free_q <= nf_inc;
        if ((nf_inc == ((P+1)'(1) << cw_q)) && (cw_q < 4'(P))) begin
          cw_q <= cw_q + 4'd1;
        end
      end
      if (cmd_i.walk_end) begin
        prev_code_q  <= code_q;
        prev_valid_q <= 1'b1;
      end
    end
  end

  assign out_o = out_q;

endmodule

// ----- rtl/gif_lzw_decoder_core.sv -----
// Channel   Direction  Handshake              Payload
// cfg       in         cfg_we_i               cfg_wdata_i (min code size)
// in        in         in_valid_i/in_stall_o  in_data_i (action, data_byte)
// out       out        out_valid_o/out_stall_i out_data_o (pixel, status, string_end)
//
// One transaction at a time. Feed, restart and pulls answered from the flags pass the
// execute and output steps; a pull from a filled stack adds a pop step, one that reads
// a clear, stop or bad code a classify step. A pull decoding a new code adds classify,
// a prefix chain walk through the registered dictionary read port (a read and a push step
// per link) and pop. Reset is asynchronous, active low, and needs no clearing pass.
// A result waiting on out_stall_i holds the next transaction in its output step.
module gif_lzw_decoder_core #(
  parameter int unsigned MAX_CODE_BITS = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [3:0]     cfg_wdata_i,
  input  logic           in_valid_i,
  input  glzw_pkg::in_t  in_data_i,
  output logic           in_stall_o,
  output logic           out_valid_o,
  output glzw_pkg::out_t out_data_o,
  input  logic           out_stall_i
);

  glzw_pkg::cmd_t cmd;
  glzw_pkg::sts_t sts;

  // Sequencer.
  glzw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_data_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Bit buffer, dictionary, string stack and result register.
  glzw_dp #(
    .MAX_CODE_BITS (MAX_CODE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_byte_i   (in_data_i.data_byte),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_data_o)
  );

endmodule

// ----- rtl/glzw_checker.sv -----
`include "gif_lzw_decoder_core_defines.svh"

module glzw_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input glzw_pkg::out_t out_data_o
);

  logic non_byte;
  logic pixel_clear;
  logic in_take;
  logic out_wait;

  assign non_byte    = out_valid_o && (out_data_o.status != glzw_pkg::ST_BYTE);
  assign pixel_clear = (out_data_o.pixel == 8'd0) && !out_data_o.string_end;
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_wait    = out_valid_o && out_stall_i;

  // Only a decoded byte carries a pixel value or a string end mark.
  `GLZW_ASSERT_NOW(a_non_byte_zero, non_byte, pixel_clear)

  // The block works on one transaction at a time.
  `GLZW_ASSERT_NEXT(a_one_at_a_time, in_take, in_stall_o)

  // A stalled result holds.
  `GLZW_ASSERT_NEXT(a_out_hold, out_wait, out_valid_o && $stable(out_data_o))

endmodule

bind gif_lzw_decoder_core glzw_checker u_glzw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
